[rtl/rpce_pkg.sv]
// Package: word types and constants for the run-length pair-count encoder.
`default_nettype none

package rpce_pkg;

  localparam int unsigned ByteW = 8;
  // output queue slots: two words per input plus one in flight
  localparam int unsigned QueueDepth = 3;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);
  localparam logic [ByteW-1:0] MaxRepeatsReset = 8'd255;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_stream;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] code_byte;
    logic             is_count;
    logic             last_of_burst;
  } out_t;

endpackage

`default_nettype wire

[rtl/rle_pair_count_encoder.sv]
// Top level: streaming byte run-length encoder with double-byte escape.
`default_nettype none

// Takes one byte per cycle while the input is ready. Each byte updates the run
// state in the same cycle and pushes zero, one or two words into a three-entry
// output queue whose head drives the output port. Input is ready while the
// queue holds at most one word, so with a steady output one byte is taken every
// cycle; a byte that produces two words (count then literal, or literal then a
// flushed count) can hold the input back while the single output port drains
// them. Bytes that only extend a run produce nothing unless the count reaches
// max_repeats or the stream ends. Words are registered in the queue before the
// output. The max_repeats register is written through the always-ready cfg port.
module rle_pair_count_encoder
  import rpce_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output out_t             out_data_o,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire [ByteW-1:0]  cfg_data_i
);

  logic [ByteW-1:0] max_repeats_q;
  logic [ByteW-1:0] prev_byte_q, prev_byte_d;
  logic             prev_valid_q, prev_valid_d;
  logic             run_open_q, run_open_d;
  logic [ByteW-1:0] count_q, count_d;

  out_t                 queue_q [QueueDepth];
  out_t                 queue_d [QueueDepth];
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  logic             accept, pop;
  logic [1:0]       n_res;
  out_t             res0, res1;
  logic [ByteW-1:0] count_inc;
  logic [QueueCntW-1:0] base;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q <= QueueCntW'(1));
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = queue_q[0];
  assign pop         = out_valid_o & out_ready_i;
  assign count_inc   = count_q + 8'd1;

  // run state update and result words for one input byte
  always_comb begin
    prev_byte_d  = prev_byte_q;
    prev_valid_d = prev_valid_q;
    run_open_d   = run_open_q;
    count_d      = count_q;
    n_res        = 2'd0;
    res0         = '{code_byte: in_data_i.data_byte, is_count: 1'b0, last_of_burst: 1'b0};
    res1         = res0;
    if (run_open_q) begin
      if (in_data_i.data_byte == prev_byte_q) begin
        count_d = count_inc;
        if (count_inc >= max_repeats_q) begin
          res0         = '{code_byte: count_inc, is_count: 1'b1, last_of_burst: 1'b0};
          n_res        = 2'd1;
          run_open_d   = 1'b0;
          count_d      = '0;
          prev_valid_d = 1'b0;
        end
      end else begin
        res0         = '{code_byte: count_q, is_count: 1'b1, last_of_burst: 1'b0};
        res1         = '{code_byte: in_data_i.data_byte, is_count: 1'b0,
                         last_of_burst: 1'b0};
        n_res        = 2'd2;
        run_open_d   = 1'b0;
        count_d      = '0;
        prev_byte_d  = in_data_i.data_byte;
        prev_valid_d = 1'b1;
      end
    end else begin
      n_res = 2'd1;
      if (prev_valid_q && in_data_i.data_byte == prev_byte_q) begin
        run_open_d = 1'b1;
        count_d    = '0;
      end else begin
        prev_byte_d  = in_data_i.data_byte;
        prev_valid_d = 1'b1;
      end
    end
    if (in_data_i.end_of_stream) begin
      // flush a run still open after this byte: alone when the byte only
      // extended it, behind the literal when the byte opened it
      if (run_open_d) begin
        if (n_res == 2'd0) begin
          res0  = '{code_byte: count_d, is_count: 1'b1, last_of_burst: 1'b0};
          n_res = 2'd1;
        end else begin
          res1  = '{code_byte: count_d, is_count: 1'b1, last_of_burst: 1'b0};
          n_res = 2'd2;
        end
      end
      prev_byte_d  = '0;
      prev_valid_d = 1'b0;
      run_open_d   = 1'b0;
      count_d      = '0;
    end
    if (n_res == 2'd1) begin
      res0.last_of_burst = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last_of_burst = 1'b1;
    end
  end

  // output queue: shift on pop, append new words behind the survivors
  always_comb begin
    base = cnt_q - QueueCntW'(pop);
    for (int i = 0; i < QueueDepth; i++) begin
      if (pop && i < QueueDepth - 1) begin
        queue_d[i] = queue_q[i+1];
      end else begin
        queue_d[i] = queue_q[i];
      end
      if (accept && n_res != 2'd0 && QueueCntW'(i) == base) begin
        queue_d[i] = res0;
      end
      if (accept && n_res == 2'd2 && QueueCntW'(i) == base + QueueCntW'(1)) begin
        queue_d[i] = res1;
      end
    end
    cnt_d = accept ? base + QueueCntW'(n_res) : base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_repeats_q <= MaxRepeatsReset;
      prev_byte_q   <= '0;
      prev_valid_q  <= 1'b0;
      run_open_q    <= 1'b0;
      count_q       <= '0;
      cnt_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_repeats_q <= cfg_data_i;
      end
      if (accept) begin
        prev_byte_q  <= prev_byte_d;
        prev_valid_q <= prev_valid_d;
        run_open_q   <= run_open_d;
        count_q      <= count_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QueueDepth; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

endmodule

`default_nettype wire
